@@ sv/qrr_pkg.sv @@
`timescale 1ns / 1ps

package qrr_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COEF_W      = 32;
	localparam int DISC_W      = 65;
	localparam int ROOT_W      = 34;
	localparam int RAD_W       = 2 * ROOT_W;
	localparam int REM_W       = ROOT_W + 2;
	localparam int NUM_W       = ROOT_W + 2;
	localparam int MAG_W       = ROOT_W;
	localparam int DIVD_W      = MAG_W + FRAC_BITS + 2;
	localparam int DEN_W       = COEF_W + 1;
	localparam int Q_W         = COEF_W;
	localparam int DISC_STAGES = 3;
	localparam int SQRT_STAGES = ROOT_W;
	localparam int DIV_STAGES  = Q_W + 1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_AZERO = 2'd1;
	localparam logic [1:0] ST_NEG  = 2'd2;
	localparam logic [1:0] ST_SAT  = 2'd3;

	typedef struct packed {
		logic signed [COEF_W-1:0] coef_a;
		logic signed [COEF_W-1:0] coef_b;
		logic signed [COEF_W-1:0] coef_c;
	} in_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] root_plus;
		logic signed [COEF_W-1:0] root_minus;
		logic [1:0]               status;
	} out_t;

	// per-item context that rides alongside the arithmetic
	typedef struct packed {
		logic [1:0]               code;
		logic                     a_neg;
		logic [COEF_W-1:0]        ua;
		logic signed [COEF_W-1:0] b;
	} ctx_t;

	typedef struct packed {
		logic [Q_W-1:0] q;
		logic           ovf;
		logic           neg;
	} quo_t;

	typedef struct packed {
		logic [COEF_W-1:0] val;
		logic              sat;
	} root_t;

endpackage

@@ sv/qrr_disc.sv @@
`timescale 1ns / 1ps

module qrr_disc import qrr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  in_t               in_data,
	output logic              disc_valid,
	output ctx_t              disc_ctx,
	output logic [DISC_W-1:0] disc
);

	logic              vld_s1, vld_s2, vld_s3;
	logic [COEF_W-1:0] ub_s1, uc_s1;
	logic              c_neg_s1;
	ctx_t              ctx_s1, ctx_s2, ctx_s3;
	logic [63:0]       bb_s2, acm_s2;
	logic              ac_neg_s2;
	logic [DISC_W-1:0] disc_s3;

	logic [63:0] bb_c, acm_c;
	logic [65:0] four_ac, bb_w, sum_c, diff_c;
	logic        neg_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1.code  <= (in_data.coef_a == '0) ? ST_AZERO : ST_OK;
			ctx_s1.a_neg <= in_data.coef_a[COEF_W-1];
			ctx_s1.ua    <= in_data.coef_a[COEF_W-1] ?
				(~in_data.coef_a + 32'd1) : in_data.coef_a;
			ctx_s1.b     <= in_data.coef_b;
			ub_s1        <= in_data.coef_b[COEF_W-1] ?
				(~in_data.coef_b + 32'd1) : in_data.coef_b;
			uc_s1        <= in_data.coef_c[COEF_W-1] ?
				(~in_data.coef_c + 32'd1) : in_data.coef_c;
			c_neg_s1     <= in_data.coef_c[COEF_W-1];
		end
	end

	// stage 2: b^2 and |a*c|
	assign bb_c  = {32'd0, ub_s1} * {32'd0, ub_s1};
	assign acm_c = {32'd0, ctx_s1.ua} * {32'd0, uc_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s2      <= ctx_s1;
			bb_s2       <= bb_c;
			acm_s2      <= acm_c;
			ac_neg_s2   <= (ctx_s1.a_neg != c_neg_s1) && (ctx_s1.ua != '0) && (uc_s1 != '0);
		end
	end

	// stage 3: b^2 - 4ac as a magnitude
	assign four_ac = {acm_s2, 2'b00};
	assign bb_w    = {2'b00, bb_s2};
	assign sum_c   = bb_w + four_ac;
	assign diff_c  = bb_w - four_ac;
	assign neg_c   = four_ac > bb_w;

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s3.a_neg <= ctx_s2.a_neg;
			ctx_s3.ua    <= ctx_s2.ua;
			ctx_s3.b     <= ctx_s2.b;
			ctx_s3.code  <= (ctx_s2.code == ST_OK && !ac_neg_s2 && neg_c) ?
				ST_NEG : ctx_s2.code;
			disc_s3 <= ac_neg_s2 ? sum_c[DISC_W-1:0] : diff_c[DISC_W-1:0];
		end
	end

	assign disc_valid = vld_s3;
	assign disc_ctx   = ctx_s3;
	assign disc       = disc_s3;

endmodule

@@ sv/qrr_sqrt.sv @@
`timescale 1ns / 1ps

module qrr_sqrt import qrr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  ctx_t              in_ctx,
	input  logic [DISC_W-1:0] disc,
	output logic              root_valid,
	output ctx_t              root_ctx,
	output logic [ROOT_W-1:0] root
);

	logic              vld_s  [0:SQRT_STAGES];
	ctx_t              ctx_s  [0:SQRT_STAGES];
	logic [REM_W-1:0]  rem_s  [0:SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [0:SQRT_STAGES];
	logic [RAD_W-1:0]  rad_s  [0:SQRT_STAGES];

	assign vld_s[0]  = in_valid;
	assign ctx_s[0]  = in_ctx;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = {{(RAD_W-DISC_W){1'b0}}, disc};

	// one result bit per stage, two radicand bits in
	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
		logic [REM_W+1:0] rem_sh, trial;
		logic             take;

		assign rem_sh = {rem_s[i], rad_s[i][RAD_W-1 -: 2]};
		assign trial  = {2'b00, root_s[i], 2'b01};
		assign take   = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[i+1] <= 1'b0;
			else if (en)
				vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[i+1]  <= ctx_s[i];
				rad_s[i+1]  <= {rad_s[i][RAD_W-3:0], 2'b00};
				rem_s[i+1]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
				root_s[i+1] <= {root_s[i][ROOT_W-2:0], take};
			end
		end
	end

	assign root_valid = vld_s[SQRT_STAGES];
	assign root_ctx   = ctx_s[SQRT_STAGES];
	assign root       = root_s[SQRT_STAGES];

endmodule

@@ sv/qrr_div.sv @@
`timescale 1ns / 1ps

module qrr_div import qrr_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic                    a_neg,
	input  logic [COEF_W-1:0]       ua,
	output quo_t                    quo
);

	localparam int HI_W = DIVD_W - Q_W;

	logic [NUM_W-1:0]  mag_c;
	logic [DIVD_W-1:0] divd_c;
	logic [DEN_W-1:0]  den_c;

	logic [DEN_W-1:0] rem_s [0:Q_W];
	logic [Q_W-1:0]   lo_s  [0:Q_W];
	logic [Q_W-1:0]   q_s   [0:Q_W];
	logic [DEN_W-1:0] den_s [0:Q_W];
	logic             ovf_s [0:Q_W];
	logic             neg_s [0:Q_W];

	assign mag_c  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign divd_c = {2'b00, mag_c[MAG_W-1:0], {FRAC_BITS{1'b0}}}
		+ {{(DIVD_W-COEF_W){1'b0}}, ua};
	assign den_c  = {ua, 1'b0};

	// prep stage: rounded dividend, overflow when the quotient needs more than Q_W bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(divd_c[DIVD_W-1:Q_W]);
			lo_s[0]  <= divd_c[Q_W-1:0];
			q_s[0]   <= '0;
			den_s[0] <= den_c;
			ovf_s[0] <= {{(DEN_W-HI_W){1'b0}}, divd_c[DIVD_W-1:Q_W]} >= den_c;
			neg_s[0] <= num[NUM_W-1] != a_neg;
		end
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_stage
		logic [DEN_W:0] rem_sh;
		logic           take;

		assign rem_sh = {rem_s[i], lo_s[i][Q_W-1]};
		assign take   = rem_sh >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? DEN_W'(rem_sh - {1'b0, den_s[i]}) : DEN_W'(rem_sh);
				lo_s[i+1]  <= {lo_s[i][Q_W-2:0], 1'b0};
				q_s[i+1]   <= {q_s[i][Q_W-2:0], take};
				den_s[i+1] <= den_s[i];
				ovf_s[i+1] <= ovf_s[i];
				neg_s[i+1] <= neg_s[i];
			end
		end
	end

	assign quo.q   = q_s[Q_W];
	assign quo.ovf = ovf_s[Q_W];
	assign quo.neg = neg_s[Q_W];

endmodule

@@ sv/quadratic_real_roots.sv @@
`timescale 1ns / 1ps
// Pipeline: 3 discriminant stages, 34 square-root stages, 33 divider stages,
// 1 output register.
// Throughput: one item per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: arst_n clears all valid bits; payload registers are not reset.

module quadratic_real_roots import qrr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	logic              en;
	logic              disc_valid, root_valid;
	ctx_t              disc_ctx, root_ctx;
	logic [DISC_W-1:0] disc;
	logic [ROOT_W-1:0] root;
	logic signed [NUM_W-1:0] nb, s_ext, num_p, num_m;
	quo_t              quo_p, quo_m;
	root_t             rp, rm;

	logic       vld_d  [0:DIV_STAGES-1];
	logic [1:0] code_d [0:DIV_STAGES-1];
	logic       out_valid_q;
	out_t       out_data_q;

	function automatic root_t finish(input quo_t qt);
		root_t r;
		r.sat = 1'b0;
		if (qt.neg) begin
			if (qt.ovf || qt.q > 32'h8000_0000) begin
				r.sat = 1'b1;
				r.val = 32'h8000_0000;
			end else begin
				r.val = ~qt.q + 32'd1;
			end
		end else if (qt.ovf || qt.q[Q_W-1]) begin
			r.sat = 1'b1;
			r.val = 32'h7FFF_FFFF;
		end else begin
			r.val = qt.q;
		end
		return r;
	endfunction

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	qrr_disc u_disc (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.in_data    (in_data),
		.disc_valid (disc_valid),
		.disc_ctx   (disc_ctx),
		.disc       (disc)
	);

	qrr_sqrt u_sqrt (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (disc_valid),
		.in_ctx     (disc_ctx),
		.disc       (disc),
		.root_valid (root_valid),
		.root_ctx   (root_ctx),
		.root       (root)
	);

	assign nb    = -NUM_W'(root_ctx.b);
	assign s_ext = {{(NUM_W-ROOT_W){1'b0}}, root};
	assign num_p = nb + s_ext;
	assign num_m = nb - s_ext;

	qrr_div u_div_p (
		.clk   (clk),
		.en    (en),
		.num   (num_p),
		.a_neg (root_ctx.a_neg),
		.ua    (root_ctx.ua),
		.quo   (quo_p)
	);

	qrr_div u_div_m (
		.clk   (clk),
		.en    (en),
		.num   (num_m),
		.a_neg (root_ctx.a_neg),
		.ua    (root_ctx.ua),
		.quo   (quo_m)
	);

	// carry valid and status code alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++)
				vld_d[k] <= 1'b0;
		end else if (en) begin
			vld_d[0] <= root_valid;
			for (int k = 1; k < DIV_STAGES; k++)
				vld_d[k] <= vld_d[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			code_d[0] <= root_ctx.code;
			for (int k = 1; k < DIV_STAGES; k++)
				code_d[k] <= code_d[k-1];
		end
	end

	assign rp = finish(quo_p);
	assign rm = finish(quo_m);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= vld_d[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (code_d[DIV_STAGES-1] != ST_OK) begin
				out_data_q.root_plus  <= '0;
				out_data_q.root_minus <= '0;
				out_data_q.status     <= code_d[DIV_STAGES-1];
			end else begin
				out_data_q.root_plus  <= rp.val;
				out_data_q.root_minus <= rm.val;
				out_data_q.status     <= (rp.sat || rm.sat) ? ST_SAT : ST_OK;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
